>>> rtl/llc_pkg.sv
`default_nettype none

package llc_pkg;

  // Table geometry and field widths.
  localparam int LEVELS  = 8;
  localparam int LVL_W   = 3;
  localparam int ENTRY_W = 9;
  localparam int DUTY_W  = 8;
  localparam int FUNC_W  = 4;
  localparam int BAT_W   = 2;
  localparam int CIDX_W  = $clog2(LEVELS);

  localparam logic [LVL_W-1:0]   TOP_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [ENTRY_W-1:0] END_MARK = '1;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_SET     = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_BLACK   = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_OFF     = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOW     = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_UP      = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_DOWN    = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_MAX     = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_RESTORE = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_STORE   = 4'd8;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE  = 4'd9;
  localparam logic [FUNC_W-1:0] FUNC_BATTERY = 4'd10;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 4'd11;

  // Battery colors.
  localparam logic [BAT_W-1:0] BAT_GREEN  = 2'd0;
  localparam logic [BAT_W-1:0] BAT_ORANGE = 2'd1;
  localparam logic [BAT_W-1:0] BAT_RED    = 2'd2;
  localparam logic [BAT_W-1:0] BAT_BLACK  = 2'd3;

  // Fixed levels used by the direct commands.
  localparam logic [LVL_W-1:0] LVL_BLACK = 3'd0;
  localparam logic [LVL_W-1:0] LVL_OFF   = 3'd1;
  localparam logic [LVL_W-1:0] LVL_LOW   = 3'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LVL_W-1:0]  new_level;
    logic [BAT_W-1:0]  battery_color;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level_index;
    logic [LVL_W-1:0]  previous_index;
    logic [DUTY_W-1:0] duty;
    logic              duty_written;
    logic [LVL_W-1:0]  max_allowed;
  } out_item_t;

  // Lookup request from the command logic to the level table.
  typedef struct packed {
    logic [LVL_W-1:0] lvl_sel;
    logic [BAT_W-1:0] battery;
  } tbl_req_t;

  // Lookup response: duty of the selected level and the allowed top level.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [LVL_W-1:0]  max_allowed;
  } tbl_rsp_t;

endpackage

`default_nettype wire

>>> rtl/llc_table.sv
`default_nettype none

module llc_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [llc_pkg::CIDX_W-1:0]    wr_index,
  input  wire logic [llc_pkg::ENTRY_W-1:0]   wr_data,
  input  wire llc_pkg::tbl_req_t             req,
  output llc_pkg::tbl_rsp_t                  rsp
);

  logic [llc_pkg::ENTRY_W-1:0] duty_r [llc_pkg::LEVELS];
  logic [llc_pkg::LVL_W-1:0]   top_lvl;
  logic [llc_pkg::LVL_W-1:0]   lvl_clamped;

  // Duty table registers; every entry resets to the end marker.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < llc_pkg::LEVELS; i++) begin
        duty_r[i] <= llc_pkg::END_MARK;
      end
    end else if (wr_en) begin
      duty_r[wr_index] <= wr_data;
    end
  end

  // Top level is one below the lowest end marker at position one or above.
  always_comb begin
    top_lvl = llc_pkg::TOP_LVL;
    for (int i = llc_pkg::LEVELS - 1; i > 0; i--) begin
      if (duty_r[i] == llc_pkg::END_MARK) begin
        top_lvl = llc_pkg::LVL_W'(i - 1);
      end
    end
  end

  // Allowed top level for the battery color, saturating at zero.
  always_comb begin
    case (req.battery)
      llc_pkg::BAT_GREEN:  rsp.max_allowed = top_lvl;
      llc_pkg::BAT_ORANGE: rsp.max_allowed = (top_lvl >= 3'd1) ? top_lvl - 3'd1 : '0;
      llc_pkg::BAT_RED:    rsp.max_allowed = (top_lvl >= 3'd2) ? top_lvl - 3'd2 : '0;
      default:             rsp.max_allowed = '0;
    endcase
  end

  // Duty lookup; a level past the table reads the last entry.
  assign lvl_clamped = ({1'b0, req.lvl_sel} >= (llc_pkg::LVL_W + 1)'(llc_pkg::LEVELS))
                       ? llc_pkg::TOP_LVL : req.lvl_sel;
  assign rsp.duty = duty_r[lvl_clamped][llc_pkg::DUTY_W-1:0];

endmodule

`default_nettype wire

>>> rtl/llc_exec.sv
`default_nettype none

module llc_exec (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire llc_pkg::in_item_t  item,
  output llc_pkg::tbl_req_t       req,
  input  wire llc_pkg::tbl_rsp_t  rsp,
  output llc_pkg::out_item_t      result
);

  logic [llc_pkg::LVL_W-1:0]  cur_r, cur_nxt;
  logic [llc_pkg::LVL_W-1:0]  sto_r, sto_nxt;
  logic [llc_pkg::BAT_W-1:0]  bat_r, bat_nxt;
  logic [llc_pkg::DUTY_W-1:0] duty_r, duty_nxt;
  logic                       apply_en;
  logic [llc_pkg::LVL_W-1:0]  apply_raw;
  logic [llc_pkg::LVL_W-1:0]  apply_lvl;
  logic [llc_pkg::LVL_W-1:0]  ma;

  // The battery command takes effect before the limit is evaluated.
  assign bat_nxt = (item.func == llc_pkg::FUNC_BATTERY) ? item.battery_color : bat_r;
  assign ma      = rsp.max_allowed;

  // Command decode: which level to apply and whether the stored level moves.
  always_comb begin
    apply_en  = 1'b0;
    apply_raw = cur_r;
    sto_nxt   = sto_r;
    case (item.func)
      llc_pkg::FUNC_SET: begin
        apply_en  = 1'b1;
        apply_raw = item.new_level;
      end
      llc_pkg::FUNC_BLACK: begin
        apply_en  = 1'b1;
        apply_raw = llc_pkg::LVL_BLACK;
      end
      llc_pkg::FUNC_OFF: begin
        apply_en  = 1'b1;
        apply_raw = llc_pkg::LVL_OFF;
      end
      llc_pkg::FUNC_LOW: begin
        apply_en  = 1'b1;
        apply_raw = llc_pkg::LVL_LOW;
      end
      llc_pkg::FUNC_UP: begin
        apply_en  = (cur_r < ma);
        apply_raw = cur_r + 3'd1;
      end
      llc_pkg::FUNC_DOWN: begin
        apply_en  = (cur_r > 3'd1);
        apply_raw = cur_r - 3'd1;
      end
      llc_pkg::FUNC_MAX: begin
        apply_en  = (cur_r != ma);
        apply_raw = ma;
      end
      llc_pkg::FUNC_RESTORE: begin
        apply_en  = (cur_r != sto_r);
        apply_raw = sto_r;
      end
      llc_pkg::FUNC_STORE: begin
        sto_nxt = cur_r;
      end
      llc_pkg::FUNC_TOGGLE: begin
        apply_en = 1'b1;
        if (cur_r >= ma) begin
          apply_raw = (ma < sto_r) ? ma : sto_r;
        end else begin
          sto_nxt   = cur_r;
          apply_raw = ma;
        end
      end
      llc_pkg::FUNC_BATTERY: begin
        apply_en  = (cur_r > ma);
        apply_raw = ma;
      end
      default: begin
        apply_en = 1'b0;
      end
    endcase
  end

  // Levels past the table clamp to the last level.
  assign apply_lvl = ({1'b0, apply_raw} >= (llc_pkg::LVL_W + 1)'(llc_pkg::LEVELS))
                     ? llc_pkg::TOP_LVL : apply_raw;

  assign req.lvl_sel = apply_lvl;
  assign req.battery = bat_nxt;

  assign cur_nxt  = apply_en ? apply_lvl : cur_r;
  assign duty_nxt = apply_en ? rsp.duty : duty_r;

  // Controller state advances once per executed command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      sto_r  <= '0;
      bat_r  <= llc_pkg::BAT_GREEN;
      duty_r <= '0;
    end else if (fire) begin
      cur_r  <= cur_nxt;
      sto_r  <= sto_nxt;
      bat_r  <= bat_nxt;
      duty_r <= duty_nxt;
    end
  end

  assign result.level_index    = cur_nxt;
  assign result.previous_index = sto_nxt;
  assign result.duty           = duty_nxt;
  assign result.duty_written   = apply_en;
  assign result.max_allowed    = ma;

endmodule

`default_nettype wire

>>> rtl/led_level_controller.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_data (func, new_level, battery_color)
// out_      output     out_valid / out_ready   out_data (level, previous, duty, strobe, limit)
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data (duty table entry)
//
// One command is accepted per cycle unless the result stalls; its result passes through the
// input register, then the result register, before it is valid and can transfer out.
// The command decode and table lookup sit between the input and the result register.
// Reset is synchronous and active low; it clears the level state and fills the table
// with end markers. A stalled result holds the result register, the next command waits
// in the input register, and input ready drops once both are full. cfg_ready is always high.
`default_nettype none

module led_level_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire llc_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output llc_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [llc_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic signed [llc_pkg::ENTRY_W-1:0] cfg_data
);

  logic               in_valid_r;
  llc_pkg::in_item_t  in_data_r;
  logic               out_valid_r;
  llc_pkg::out_item_t out_data_r;
  logic               fire;
  logic               in_xfer;
  llc_pkg::tbl_req_t  req;
  llc_pkg::tbl_rsp_t  rsp;
  llc_pkg::out_item_t result;

  // A held command executes when the result register is free or being drained.
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign in_xfer  = in_valid && in_ready;

  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_data;
    end
  end

  llc_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  llc_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_data_r),
    .req    (req),
    .rsp    (rsp),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/llc_checker.sv
`default_nettype none

module llc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire llc_pkg::out_item_t            out_data
);

  logic [1:0]                  pend_r;
  logic [llc_pkg::LVL_W-1:0]   last_lvl_r;
  logic [llc_pkg::DUTY_W-1:0]  last_duty_r;
  logic                        in_xfer;
  logic                        out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Commands taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // Level and duty of the last delivered result, starting from the reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lvl_r  <= '0;
      last_duty_r <= '0;
    end else if (out_xfer) begin
      last_lvl_r  <= out_data.level_index;
      last_duty_r <= out_data.duty;
    end
  end

  // No result without a command behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no command pending");

  // At most two commands are in flight.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more commands in flight than the pipeline holds");

  // A result that did not rewrite the duty keeps the previous level and duty.
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.duty_written |->
      out_data.level_index == last_lvl_r && out_data.duty == last_duty_r)
    else $error("level or duty changed without a duty write");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind led_level_controller llc_checker u_llc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/tb_led_level_controller.sv
`default_nettype none

module tb_led_level_controller;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 72;
  localparam int DRAIN_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  llc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  llc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [llc_pkg::CIDX_W-1:0]         cfg_index = '0;
  logic signed [llc_pkg::ENTRY_W-1:0] cfg_data = '0;

  led_level_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Commands waiting to be offered and block status we still wait for.
  llc_pkg::in_item_t  pending_cmds[$];
  llc_pkg::out_item_t expected_status[$];
  int                 mismatch_count = 0;

  // Shadow copy of the level state and the duty table.
  logic signed [llc_pkg::ENTRY_W-1:0] duty_tab [llc_pkg::LEVELS];
  logic signed [llc_pkg::ENTRY_W-1:0] next_tab [llc_pkg::LEVELS];
  logic [llc_pkg::LVL_W-1:0]  lvl_now = '0;
  logic [llc_pkg::LVL_W-1:0]  lvl_saved = '0;
  logic [llc_pkg::BAT_W-1:0]  bat_now = llc_pkg::BAT_GREEN;
  logic [llc_pkg::DUTY_W-1:0] duty_now = '0;
  logic                       duty_strobe = 1'b0;

  // The top level sits one below the lowest end marker above entry zero.
  function automatic logic [llc_pkg::LVL_W-1:0] table_top();
    logic [llc_pkg::LVL_W-1:0] top;
    top = llc_pkg::TOP_LVL;
    for (int i = llc_pkg::LEVELS - 1; i > 0; i--) begin
      if (duty_tab[i] == llc_pkg::END_MARK) top = llc_pkg::LVL_W'(i - 1);
    end
    return top;
  endfunction

  // The battery color lowers the allowed top level, saturating at zero.
  function automatic logic [llc_pkg::LVL_W-1:0] battery_limit();
    logic [llc_pkg::LVL_W-1:0] top;
    top = table_top();
    case (bat_now)
      llc_pkg::BAT_GREEN:  return top;
      llc_pkg::BAT_ORANGE: return (top >= 1) ? top - 1'b1 : '0;
      llc_pkg::BAT_RED:    return (top >= 2) ? top - 2'd2 : '0;
      default:             return '0;
    endcase
  endfunction

  function automatic void apply_level(int lvl);
    lvl_now     = (lvl >= llc_pkg::LEVELS) ? llc_pkg::TOP_LVL : llc_pkg::LVL_W'(lvl);
    duty_now    = duty_tab[lvl_now][llc_pkg::DUTY_W-1:0];
    duty_strobe = 1'b1;
  endfunction

  // Advance the shadow state by one command and return the status it leaves.
  function automatic llc_pkg::out_item_t led_status_after(llc_pkg::in_item_t cmd);
    logic [llc_pkg::LVL_W-1:0] lim;
    llc_pkg::out_item_t        st;
    duty_strobe = 1'b0;
    case (cmd.func)
      llc_pkg::FUNC_SET:   apply_level(cmd.new_level);
      llc_pkg::FUNC_BLACK: apply_level(llc_pkg::LVL_BLACK);
      llc_pkg::FUNC_OFF:   apply_level(llc_pkg::LVL_OFF);
      llc_pkg::FUNC_LOW:   apply_level(llc_pkg::LVL_LOW);
      llc_pkg::FUNC_UP: begin
        if (lvl_now < battery_limit()) apply_level(lvl_now + 1);
      end
      llc_pkg::FUNC_DOWN: begin
        if (lvl_now > 1) apply_level(lvl_now - 1);
      end
      llc_pkg::FUNC_MAX: begin
        lim = battery_limit();
        if (lvl_now != lim) apply_level(lim);
      end
      llc_pkg::FUNC_RESTORE: begin
        if (lvl_now != lvl_saved) apply_level(lvl_saved);
      end
      llc_pkg::FUNC_STORE: lvl_saved = lvl_now;
      llc_pkg::FUNC_TOGGLE: begin
        lim = battery_limit();
        if (lvl_now >= lim) begin
          apply_level((lim < lvl_saved) ? lim : lvl_saved);
        end else begin
          lvl_saved = lvl_now;
          apply_level(lim);
        end
      end
      llc_pkg::FUNC_BATTERY: begin
        bat_now = cmd.battery_color;
        lim = battery_limit();
        if (lvl_now > lim) apply_level(lim);
      end
      default: ;
    endcase
    st.level_index    = lvl_now;
    st.previous_index = lvl_saved;
    st.duty           = duty_now;
    st.duty_written   = duty_strobe;
    st.max_allowed    = battery_limit();
    return st;
  endfunction

  function automatic llc_pkg::in_item_t make_cmd(logic [llc_pkg::FUNC_W-1:0] f,
                                                 int nl = 0, int bc = 0);
    llc_pkg::in_item_t c;
    c.func          = f;
    c.new_level     = llc_pkg::LVL_W'(nl);
    c.battery_color = llc_pkg::BAT_W'(bc);
    return c;
  endfunction

  function automatic llc_pkg::in_item_t random_cmd();
    logic [llc_pkg::FUNC_W-1:0] f;
    if ($urandom_range(0, 99) < 92) begin
      f = llc_pkg::FUNC_W'($urandom_range(0, llc_pkg::FUNC_QUERY));
    end else begin
      f = llc_pkg::FUNC_W'($urandom_range(llc_pkg::FUNC_QUERY + 1, 15));
    end
    return make_cmd(f, $urandom_range(0, llc_pkg::LEVELS - 1), $urandom_range(0, 3));
  endfunction

  // Random table entries, biased toward end markers and the value extremes.
  function automatic logic signed [llc_pkg::ENTRY_W-1:0] random_entry();
    case ($urandom_range(0, 7))
      0, 1:    return llc_pkg::END_MARK;
      2:       return llc_pkg::ENTRY_W'(-int'($urandom_range(2, 256)));
      3:       return '0;
      4:       return llc_pkg::ENTRY_W'(255);
      default: return llc_pkg::ENTRY_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Write every table entry through the configuration port.
  task automatic load_table();
    for (int i = 0; i < llc_pkg::LEVELS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= llc_pkg::CIDX_W'(i);
      cfg_data  <= next_tab[i];
      do @(posedge clk); while (!cfg_ready);
      duty_tab[i] = next_tab[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait until every command has been sent and every status has come back.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: offers queued commands in bursts separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_status.push_back(led_status_after(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern draws a new random mode at regular intervals; one long hold-off on request.
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   rx_tick = 0;
  int   rx_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      if (hold_cnt == HOLD_CYCLES) begin
        hold_done <= 1'b1;
        out_ready <= 1'b1;
      end else begin
        hold_cnt  = hold_cnt + 1;
        out_ready <= 1'b0;
      end
    end else begin
      rx_tick = rx_tick + 1;
      if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= (rx_tick % 8 < 5);
      endcase
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: every status transfer is matched against the oldest prediction.
  llc_pkg::out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("status transfer with no command outstanding: %p", out_data);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("level_index", want.level_index, out_data.level_index);
        check_field("previous_index", want.previous_index, out_data.previous_index);
        check_field("duty", want.duty, out_data.duty);
        check_field("duty_written", want.duty_written, out_data.duty_written);
        check_field("max_allowed", want.max_allowed, out_data.max_allowed);
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** led_level_controller: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < llc_pkg::LEVELS; i++) duty_tab[i] = llc_pkg::END_MARK;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Full table: entry zero holds the end marker value, other negatives are plain duties.
    next_tab = '{llc_pkg::END_MARK, 255, 0, -2, -256, 128, 1, 127};
    load_table();
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_QUERY, 7, 3));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_SET, 7));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_SET, 0));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_SET, 3));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_SET, 4));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BLACK));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_OFF));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_DOWN));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_LOW));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_UP));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_STORE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_MAX));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_UP));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_RESTORE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_RESTORE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_TOGGLE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_TOGGLE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_ORANGE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_MAX));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_RED));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_BLACK));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_GREEN));
    pending_cmds.push_back(make_cmd(4'd12, 5, 2));
    pending_cmds.push_back(make_cmd(4'd15, 2, 1));
    drain();

    // Short table with top level 1, so orange and red limits bottom out at zero.
    next_tab = '{100, 200, llc_pkg::END_MARK, 50, llc_pkg::END_MARK, 7, 9, 11};
    load_table();
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_SET, 6));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_RED));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_TOGGLE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_ORANGE));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_UP));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_BATTERY, 0, llc_pkg::BAT_GREEN));
    pending_cmds.push_back(make_cmd(llc_pkg::FUNC_UP));
    drain();

    // Random phases, each with its own table; some tables sit at the extremes.
    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int i = 0; i < llc_pkg::LEVELS; i++) begin
        case (p)
          1:       next_tab[i] = llc_pkg::ENTRY_W'(255);
          3:       next_tab[i] = llc_pkg::END_MARK;
          5:       next_tab[i] = '0;
          default: next_tab[i] = random_entry();
        endcase
      end
      load_table();
      for (int n = 0; n < PHASE_ITEMS; n++) pending_cmds.push_back(random_cmd());
      if (p == 0) hold_req <= 1'b1;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("** led_level_controller: PASSED **");
    end else begin
      $display("** led_level_controller: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
